FILE: hdl/rec_pkg.sv
// Shared types and constants for the RMS energy confidence block.
// Used by the front, back and top-level modules; depends on nothing else.

package rec_pkg;

    localparam int SAMPLE_W = 16;
    localparam int CONF_W   = 16;
    localparam int STATUS_W = 2;

    // The mean square never exceeds 2^30, so it fits in 31 bits and its root in 16.
    localparam int MEAN_W      = 31;
    localparam int ROOT_W      = 16;
    localparam int SQRT_STEPS  = 16;
    localparam int SQ_VAL_W    = 2 * SQRT_STEPS;
    localparam int SQ_REM_W    = ROOT_W + 2;

    localparam logic [CONF_W:0] CONF_ONE = 17'd32768;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_INVALID  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

    localparam logic REG_MODEL_LOADED = 1'b0;
    localparam logic REG_OUTPUT_ROOM  = 1'b1;

    typedef struct packed {
        logic model_loaded;
        logic output_room;
    } cfg_t;

endpackage

FILE: hdl/rec_queue.sv
// Small register-based queue that carries closed-window summaries from the
// front to the back. Depends on nothing; the entry width is a parameter.

module rec_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] head_data,
    output logic             full,
    output logic             empty
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    fill_reg, fill_next;

    assign full      = (fill_reg == CW'(DEPTH));
    assign empty     = (fill_reg == '0);
    assign head_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
        else $error("queue pushed while full");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n) !(pop && empty))
        else $error("queue popped while empty");
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CW'(DEPTH))
        else $error("queue fill count out of range");

endmodule

FILE: hdl/rec_front.sv
// Front end: squares each accepted sample, accumulates the window and, at the
// closing word, pushes a summary (sum, count, status) into the queue.
// Depends on rec_pkg.

module rec_front #(
    parameter int MAX_WINDOW = 1024,
    parameter int SUM_W      = 41,
    parameter int CNT_W      = 11
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  rec_pkg::cfg_t                 cfg,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [rec_pkg::SAMPLE_W-1:0] sample,
    input  logic                          last,
    input  logic                          q_full,
    output logic                          q_push,
    output logic [SUM_W-1:0]              q_sum,
    output logic [CNT_W-1:0]              q_count,
    output logic [rec_pkg::STATUS_W-1:0]  q_status
);

    import rec_pkg::*;

    logic [SUM_W-1:0]      sum_reg, sum_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  ovf_reg, ovf_next;

    logic [SAMPLE_W-1:0]   mag;
    logic [2*SAMPLE_W-1:0] square;
    logic                  window_full;
    logic                  accept;
    logic [SUM_W-1:0]      sum_upd;
    logic [CNT_W-1:0]      count_upd;
    logic                  ovf_upd;

    // The most negative sample maps to 0x8000, which is its correct magnitude.
    assign mag         = sample[SAMPLE_W-1] ? (~sample + 1'b1) : sample;
    assign square      = mag * mag;
    assign window_full = (count_reg == CNT_W'(MAX_WINDOW));
    assign in_ready    = !q_full;
    assign accept      = in_valid && in_ready;

    assign sum_upd   = window_full ? sum_reg : sum_reg + SUM_W'(square);
    assign count_upd = window_full ? count_reg : count_reg + 1'b1;
    assign ovf_upd   = ovf_reg || window_full;

    assign q_push  = accept && last;
    assign q_sum   = sum_upd;
    assign q_count = count_upd;

    always_comb
    begin
        if (!cfg.model_loaded || !cfg.output_room)
        begin
            q_status = STATUS_INVALID;
        end
        else if (ovf_upd)
        begin
            q_status = STATUS_OVERFLOW;
        end
        else
        begin
            q_status = STATUS_OK;
        end
    end

    always_comb
    begin
        sum_next   = sum_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (accept)
        begin
            if (last)
            begin
                sum_next   = '0;
                count_next = '0;
                ovf_next   = 1'b0;
            end
            else
            begin
                sum_next   = sum_upd;
                count_next = count_upd;
                ovf_next   = ovf_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            sum_reg   <= sum_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

endmodule

FILE: hdl/rec_back.sv
// Back end: takes window summaries from the queue, divides the sum by the count
// one quotient bit a cycle, takes the square root two bits a cycle, then
// doubles, clamps and holds the result word (0 for errors). Depends on rec_pkg.

module rec_back #(
    parameter int SUM_W = 41,
    parameter int CNT_W = 11
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_empty,
    input  logic [SUM_W-1:0]              q_sum,
    input  logic [CNT_W-1:0]              q_count,
    input  logic [rec_pkg::STATUS_W-1:0]  q_status,
    output logic                          q_pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [rec_pkg::CONF_W-1:0]    confidence,
    output logic [rec_pkg::STATUS_W-1:0]  status
);

    import rec_pkg::*;

    localparam int STEP_W = $clog2(SUM_W);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIV  = 4'b0010,
        ST_SQRT = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t              state_reg, state_next;
    logic [STEP_W-1:0]   step_reg, step_next;

    logic [SUM_W-1:0]    quo_reg, quo_next;
    logic [CNT_W-1:0]    rem_reg, rem_next;
    logic [CNT_W-1:0]    den_reg, den_next;

    logic [SQ_VAL_W-1:0] sq_val_reg, sq_val_next;
    logic [SQ_REM_W-1:0] sq_rem_reg, sq_rem_next;
    logic [ROOT_W-1:0]   root_reg, root_next;

    logic [CONF_W-1:0]   conf_reg, conf_next;
    logic [STATUS_W-1:0] status_reg, status_next;

    // Division step
    logic [CNT_W:0]      div_shift;
    logic [CNT_W:0]      div_diff;
    logic                div_ge;
    logic [SUM_W-1:0]    quo_step;
    logic [CNT_W-1:0]    rem_step;

    // Square root step
    logic [SQ_REM_W+1:0] sq_shift;
    logic [SQ_REM_W+1:0] sq_trial;
    logic                sq_ge;
    logic [SQ_REM_W+1:0] sq_diff;
    logic [ROOT_W-1:0]   root_step;
    logic [CONF_W:0]     doubled;

    assign div_shift = {rem_reg, quo_reg[SUM_W-1]};
    assign div_ge    = (div_shift >= {1'b0, den_reg});
    assign div_diff  = div_shift - {1'b0, den_reg};
    assign rem_step  = div_ge ? div_diff[CNT_W-1:0] : div_shift[CNT_W-1:0];
    assign quo_step  = {quo_reg[SUM_W-2:0], div_ge};

    assign sq_shift  = {sq_rem_reg, sq_val_reg[SQ_VAL_W-1 -: 2]};
    assign sq_trial  = {2'b00, root_reg, 2'b01};
    assign sq_ge     = (sq_shift >= sq_trial);
    assign sq_diff   = sq_shift - sq_trial;
    assign root_step = {root_reg[ROOT_W-2:0], sq_ge};
    assign doubled   = {root_step, 1'b0};

    assign q_pop      = (state_reg == ST_IDLE) && !q_empty;
    assign out_valid  = (state_reg == ST_DONE);
    assign confidence = conf_reg;
    assign status     = status_reg;

    always_comb
    begin
        state_next  = state_reg;
        step_next   = step_reg;
        quo_next    = quo_reg;
        rem_next    = rem_reg;
        den_next    = den_reg;
        sq_val_next = sq_val_reg;
        sq_rem_next = sq_rem_reg;
        root_next   = root_reg;
        conf_next   = conf_reg;
        status_next = status_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    status_next = q_status;
                    if (q_status != STATUS_OK)
                    begin
                        conf_next  = '0;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        quo_next   = q_sum;
                        rem_next   = '0;
                        den_next   = q_count;
                        step_next  = STEP_W'(SUM_W - 1);
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                quo_next = quo_step;
                rem_next = rem_step;
                if (step_reg == '0)
                begin
                    sq_val_next = SQ_VAL_W'(quo_step[MEAN_W-1:0]);
                    sq_rem_next = '0;
                    root_next   = '0;
                    step_next   = STEP_W'(SQRT_STEPS - 1);
                    state_next  = ST_SQRT;
                end
                else
                begin
                    step_next = step_reg - 1'b1;
                end
            end
            ST_SQRT:
            begin
                sq_val_next = {sq_val_reg[SQ_VAL_W-3:0], 2'b00};
                sq_rem_next = sq_ge ? sq_diff[SQ_REM_W-1:0] : sq_shift[SQ_REM_W-1:0];
                root_next   = root_step;
                if (step_reg == '0)
                begin
                    conf_next  = (doubled > CONF_ONE) ? CONF_ONE[CONF_W-1:0]
                                                       : doubled[CONF_W-1:0];
                    state_next = ST_DONE;
                end
                else
                begin
                    step_next = step_reg - 1'b1;
                end
            end
            ST_DONE:
            begin
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg   <= step_next;
        quo_reg    <= quo_next;
        rem_reg    <= rem_next;
        den_reg    <= den_next;
        sq_val_reg <= sq_val_next;
        sq_rem_reg <= sq_rem_next;
        root_reg   <= root_next;
        conf_reg   <= conf_next;
        status_reg <= status_next;
    end

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != STATUS_OK) |-> (confidence == '0))
        else $error("error word carries nonzero confidence");
    a_conf_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ({1'b0, confidence} <= CONF_ONE))
        else $error("confidence above 1.0");
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> !out_valid || (state_reg == ST_DONE && $past(q_status) != STATUS_OK))
        else $error("result word appeared too early after a pop");

endmodule

FILE: hdl/rms_energy_confidence_top.sv
// Top level of the RMS energy confidence detector: configuration registers
// on an APB-style port, and the front, queue and back instances.
// Depends on rec_pkg, rec_front, rec_queue and rec_back.

// The block takes one signed Q1.15 sample per word, and the front squares and
// accumulates a word every clock cycle while the queue is not full. At the
// word flagged last, a summary of the window goes into a QUEUE_DEPTH-entry
// queue, and the back turns it into one result word: confidence =
// min(2 * floor(sqrt(floor(sum / count))), 1.0) in Q1.15 with status 0, or
// confidence 0 with status 1 (model not loaded or no output room, checked when
// the last word is taken) or status 2 (window longer than MAX_WINDOW). The back
// spends one cycle per quotient bit in its restoring divider, then runs the
// two-bit-per-step square root; an error window skips both. It pops the next
// summary only once the result word is taken. The front stalls only while the
// queue is full. There is no clearing pass.

module rms_energy_confidence_top #(
    parameter int MAX_WINDOW  = 1024,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [2:0]                          paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [rec_pkg::SAMPLE_W-1:0] sample,
    input  logic                                last,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [rec_pkg::CONF_W-1:0]          confidence,
    output logic [rec_pkg::STATUS_W-1:0]        status
);

    import rec_pkg::*;

    localparam int CNT_W   = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W   = $clog2(MAX_WINDOW) + 31;
    localparam int ENTRY_W = SUM_W + CNT_W + STATUS_W;

    logic                model_loaded_reg, model_loaded_next;
    logic                output_room_reg, output_room_next;
    cfg_t                cfg;
    logic                wr_en;

    logic                q_push, q_pop, q_full, q_empty;
    logic [SUM_W-1:0]    f_sum, b_sum;
    logic [CNT_W-1:0]    f_count, b_count;
    logic [STATUS_W-1:0] f_status, b_status;
    logic [ENTRY_W-1:0]  head;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb
    begin
        model_loaded_next = model_loaded_reg;
        output_room_next  = output_room_reg;
        if (wr_en)
        begin
            case (paddr[2])
                REG_MODEL_LOADED: model_loaded_next = pwdata[0];
                REG_OUTPUT_ROOM:  output_room_next  = pwdata[0];
                default:          model_loaded_next = model_loaded_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            model_loaded_reg <= 1'b0;
            output_room_reg  <= 1'b1;
        end
        else
        begin
            model_loaded_reg <= model_loaded_next;
            output_room_reg  <= output_room_next;
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_MODEL_LOADED: prdata = {31'd0, model_loaded_reg};
            REG_OUTPUT_ROOM:  prdata = {31'd0, output_room_reg};
            default:          prdata = '0;
        endcase
    end

    assign cfg.model_loaded = model_loaded_reg;
    assign cfg.output_room  = output_room_reg;

    rec_front #(
        .MAX_WINDOW (MAX_WINDOW),
        .SUM_W      (SUM_W),
        .CNT_W      (CNT_W)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sample   (sample),
        .last     (last),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_sum    (f_sum),
        .q_count  (f_count),
        .q_status (f_status)
    );

    rec_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data ({f_status, f_count, f_sum}),
        .pop       (q_pop),
        .head_data (head),
        .full      (q_full),
        .empty     (q_empty)
    );

    assign b_sum    = head[SUM_W-1:0];
    assign b_count  = head[SUM_W +: CNT_W];
    assign b_status = head[ENTRY_W-1 -: STATUS_W];

    rec_back #(
        .SUM_W (SUM_W),
        .CNT_W (CNT_W)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_sum      (b_sum),
        .q_count    (b_count),
        .q_status   (b_status),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .confidence (confidence),
        .status     (status)
    );

endmodule
